### design/rtae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtae_pkg
// types and constants shared by the acknowledgement engine
// ----------------------------------------------------------------------------
package rtae_pkg;

    localparam logic [1:0] OP_RX_HDR = 2'd0;
    localparam logic [1:0] OP_TX_SEG = 2'd1;
    localparam logic [1:0] OP_APP_RD = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam int FLG_ACK_BIT = 1;
    localparam int FLG_FIN_BIT = 2;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_ACK  = 3'd1;
    localparam logic [2:0] ACT_DUP  = 3'd2;
    localparam logic [2:0] ACT_FIN  = 3'd3;
    localparam logic [2:0] ACT_RTX  = 3'd4;

    localparam logic [2:0] CFG_INIT_EXP = 3'd0;
    localparam logic [2:0] CFG_INIT_LOC = 3'd1;
    localparam logic [2:0] CFG_MSS      = 3'd2;
    localparam logic [2:0] CFG_CAP      = 3'd3;
    localparam logic [2:0] CFG_CWND0    = 3'd4;
    localparam logic [2:0] CFG_THRESH   = 3'd5;

    localparam logic [10:0] MSS_RST    = 11'd480;
    localparam logic [15:0] CAP_RST    = 16'd4096;
    localparam logic [15:0] CWND0_RST  = 16'd10000;
    localparam logic [3:0]  THRESH_RST = 4'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [10:0] seg_len;
        logic [15:0] rx_window;
        logic [15:0] read_len;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] ack_value;
        logic [31:0] seq_value;
        logic [15:0] adv_window;
        logic [31:0] retransmit_seq;
        logic [15:0] cwnd_now;
        logic [15:0] peer_window;
        logic        fin_seen;
        logic        error;
    } t_out_item;

    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

### design/reliable_transport_ack_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_transport_ack_engine
// header-level ack engine for one connection, send window and reorder table
// held in synchronous memories walked one entry at a time
// ----------------------------------------------------------------------------
//  channel | signals                    | direction
//  in      | i_in_valid o_in_stall i_in | transaction into the engine
//  out     | o_out_valid i_out_stall o_out | one result per transaction
//  cfg     | i_cfg_we i_cfg_idx i_cfg_data | register write
// one transaction at a time; a new one is accepted only after the last result is
// taken into the output register. each send window or valid reorder entry examined
// needs a memory read before its check, while a free reorder slot is skipped without
// one; the drain rescans the reorder table from the start after each entry it takes.
// reset is synchronous and clears control state; a result held under stall
// keeps the following transaction in its final state (S_DONE).
// ----------------------------------------------------------------------------
module reliable_transport_ack_engine #(
    parameter int SEND_WINDOW_DEPTH = 16,
    parameter int REORDER_DEPTH     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtae_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtae_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    localparam int SW = $clog2(SEND_WINDOW_DEPTH);
    localparam int RW = $clog2(REORDER_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_POP = 4'd2,
        S_SRCH = 4'd3, S_FIND = 4'd4, S_DRN = 4'd5, S_DONE = 4'd6;

    logic [31:0] r_ie, r_il;
    logic [10:0] r_mss;
    logic [15:0] r_cap, r_cw0;
    logic [3:0]  r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie <= '0; r_il <= '0; r_mss <= rtae_pkg::MSS_RST;
            r_cap <= rtae_pkg::CAP_RST; r_cw0 <= rtae_pkg::CWND0_RST;
            r_th <= rtae_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rtae_pkg::CFG_INIT_EXP: r_ie <= i_cfg_data;
                rtae_pkg::CFG_INIT_LOC: r_il <= i_cfg_data;
                rtae_pkg::CFG_MSS:      r_mss <= i_cfg_data[10:0];
                rtae_pkg::CFG_CAP:      r_cap <= i_cfg_data[15:0];
                rtae_pkg::CFG_CWND0:    r_cw0 <= i_cfg_data[15:0];
                rtae_pkg::CFG_THRESH:   r_th <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // send window memory: seq, len
    logic [42:0] r_swm [SEND_WINDOW_DEPTH];
    logic [42:0] r_swq;
    logic        sw_we;
    logic [SW-1:0] sw_wa, sw_ra;
    logic [42:0] sw_wd;
    // reorder memory: seq, len; valid bits in flops
    logic [42:0] r_rom [REORDER_DEPTH];
    logic [42:0] r_roq;
    logic        ro_we;
    logic [RW-1:0] ro_wa, ro_ra;
    logic [42:0] ro_wd;
    logic [REORDER_DEPTH-1:0] r_rv, n_rv;

    always_ff @(posedge i_clk) begin
        if (sw_we) r_swm[sw_wa] <= sw_wd;
        r_swq <= r_swm[sw_ra];
        if (ro_we) r_rom[ro_wa] <= ro_wd;
        r_roq <= r_rom[ro_ra];
    end

    logic [3:0]  r_st, n_st;
    rtae_pkg::t_in_item r_it, n_it;
    logic [31:0] r_exp, n_exp, r_loc, n_loc, r_dv, n_dv;
    logic [SW-1:0] r_hd, n_hd;
    logic [SW:0] r_cnt, n_cnt;
    logic [3:0]  r_dc, n_dc;
    logic [15:0] r_cw, n_cw, r_rw, n_rw, r_bu, n_bu;
    logic        r_fin, n_fin;
    logic [SW:0] r_k, n_k;
    logic [RW:0] r_j, n_j;
    logic        r_rd, n_rd;   // read issued last cycle, data valid now
    logic [RW:0] r_ndr, n_ndr; // drain steps done
    logic [RW:0] r_free, n_free;
    logic        r_fnd, n_fnd;
    rtae_pkg::t_out_item r_res, n_res;
    rtae_pkg::t_out_item r_out, n_out;
    logic        r_ov, n_ov;

    logic [16:0] cws;
    logic [31:0] qs, rs;
    logic [10:0] ql, rl;
    logic [16:0] bsum;

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign {qs, ql} = r_swq;
    assign {rs, rl} = r_roq;

    function automatic logic [15:0] fw(input logic [15:0] c, input logic [15:0] b);
        return (c > b) ? c - b : 16'd0;
    endfunction

    // send window index modulo depth
    function automatic logic [SW-1:0] sw_wrap(input logic [SW:0] s);
        return (s >= (SW+1)'(SEND_WINDOW_DEPTH)) ?
            SW'(s - (SW+1)'(SEND_WINDOW_DEPTH)) : s[SW-1:0];
    endfunction

    always_comb begin
        n_st = r_st; n_it = r_it; n_exp = r_exp; n_loc = r_loc; n_dv = r_dv;
        n_hd = r_hd; n_cnt = r_cnt; n_dc = r_dc; n_cw = r_cw; n_rw = r_rw;
        n_bu = r_bu; n_fin = r_fin; n_k = r_k; n_j = r_j; n_rd = 1'b0;
        n_ndr = r_ndr; n_free = r_free; n_fnd = r_fnd; n_res = r_res; n_out = r_out;
        n_rv = r_rv; n_ov = r_ov;
        sw_we = 1'b0; sw_wa = sw_wrap((SW+1)'(r_hd) + r_cnt); sw_ra = r_hd;
        sw_wd = {r_it.seq_number, r_it.seg_len};
        ro_we = 1'b0; ro_wa = '0; ro_wd = {r_it.seq_number, r_it.seg_len};
        ro_ra = r_j[RW-1:0];
        cws = 17'(r_cw) + 17'(r_mss);
        bsum = 17'(r_bu) + 17'(rl);
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_in_valid) begin
                n_it = i_in;
                n_res = '0;
                n_st = S_DISP;
                n_rd = 1'b1; // head of send window
            end
            S_DISP: begin
                n_st = S_DONE;
                unique case (r_it.operation)
                    rtae_pkg::OP_TX_SEG: begin
                        if (r_cnt == (SW+1)'(SEND_WINDOW_DEPTH)) n_res.error = 1'b1;
                        else begin
                            sw_we = 1'b1; n_cnt = r_cnt + (SW+1)'(1);
                            n_loc = r_it.seq_number + 32'(r_it.seg_len);
                        end
                    end
                    rtae_pkg::OP_APP_RD:
                        n_bu = (r_it.read_len >= r_bu) ? 16'd0 : r_bu - r_it.read_len;
                    rtae_pkg::OP_RX_HDR: begin
                        if (r_it.flags[rtae_pkg::FLG_ACK_BIT]) begin
                            n_rw = r_it.rx_window;
                            n_cw = cws[16] ? 16'hFFFF : cws[15:0];
                            if (r_cnt != 0 && rtae_pkg::seq_after(r_it.ack_number, qs)) begin
                                n_dv = '0; n_dc = '0; n_st = S_POP; n_rd = 1'b1;
                                sw_ra = r_hd;
                            end else begin
                                if (r_dc == 0 || r_dv != r_it.ack_number) begin
                                    n_dv = r_it.ack_number; n_dc = 4'd1;
                                end else if (r_dc != 4'd15) n_dc = r_dc + 4'd1;
                                if ((r_dc == 0 || r_dv != r_it.ack_number ||
                                     r_dc != 4'd15) && n_dc == r_th) begin
                                    n_cw = n_cw >> 1;
                                    n_k = '0; n_st = S_SRCH; n_rd = 1'b1;
                                end
                            end
                        end else if (r_it.flags[rtae_pkg::FLG_FIN_BIT]) begin
                            n_fin = 1'b1; n_rw = r_it.rx_window;
                            n_res.action = rtae_pkg::ACT_FIN;
                            n_res.ack_value = r_it.seq_number + 32'd1;
                            n_res.seq_value = r_loc;
                        end else if (r_it.seq_number == r_exp) begin
                            n_rw = r_it.rx_window;
                            n_res.seq_value = r_loc;
                            if (17'(r_bu) + 17'(r_it.seg_len) > 17'(r_cap)) begin
                                n_res.error = 1'b1; n_res.action = rtae_pkg::ACT_DUP;
                                n_res.ack_value = r_exp;
                            end else begin
                                n_bu = r_bu + 16'(r_it.seg_len);
                                n_exp = r_exp + 32'(r_it.seg_len);
                                n_res.action = rtae_pkg::ACT_ACK;
                                n_ndr = '0; n_j = '0; n_fnd = 1'b0; n_st = S_DRN;
                            end
                        end else if (rtae_pkg::seq_after(r_it.seq_number, r_exp)) begin
                            n_rw = r_it.rx_window;
                            n_res.action = rtae_pkg::ACT_DUP;
                            n_res.ack_value = r_exp; n_res.seq_value = r_loc;
                            n_j = '0; n_fnd = 1'b0; n_free = (RW+1)'(REORDER_DEPTH);
                            n_st = S_FIND;
                        end
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                // r_swq holds entry at r_hd
                if (!r_rd) begin
                    n_rd = 1'b1; sw_ra = r_hd;
                end else if (r_cnt == 0 ||
                        rtae_pkg::seq_after(qs + 32'(ql), r_it.ack_number)) begin
                    n_st = S_DONE;
                end else begin
                    n_hd = sw_wrap((SW+1)'(r_hd) + (SW+1)'(1));
                    n_cnt = r_cnt - (SW+1)'(1);
                end
            end
            S_SRCH: begin
                sw_ra = sw_wrap((SW+1)'(r_hd) + r_k);
                if (r_k >= r_cnt) n_st = S_DONE;
                else if (!r_rd) n_rd = 1'b1;
                else if (qs == r_it.ack_number) begin
                    n_res.action = rtae_pkg::ACT_RTX;
                    n_res.retransmit_seq = r_it.ack_number; n_st = S_DONE;
                end else begin
                    n_k = r_k + (SW+1)'(1);
                end
            end
            S_FIND: begin
                // look for a matching valid entry, track first free slot
                if (r_j == (RW+1)'(REORDER_DEPTH)) begin
                    n_st = S_DONE;
                    if (!r_fnd) begin
                        if (r_free == (RW+1)'(REORDER_DEPTH)) n_res.error = 1'b1;
                        else begin
                            ro_we = 1'b1; ro_wa = r_free[RW-1:0];
                            n_rv[r_free[RW-1:0]] = 1'b1;
                        end
                    end
                end else if (!r_rv[r_j[RW-1:0]]) begin
                    if (r_free == (RW+1)'(REORDER_DEPTH)) n_free = r_j;
                    n_j = r_j + (RW+1)'(1);
                end else if (!r_rd) n_rd = 1'b1;
                else begin
                    if (rs == r_it.seq_number) n_fnd = 1'b1;
                    n_j = r_j + (RW+1)'(1);
                end
            end
            S_DRN: begin
                if (r_ndr == (RW+1)'(REORDER_DEPTH)) n_st = S_DONE;
                else if (r_j == (RW+1)'(REORDER_DEPTH)) n_st = S_DONE;
                else if (!r_rv[r_j[RW-1:0]]) n_j = r_j + (RW+1)'(1);
                else if (!r_rd) n_rd = 1'b1;
                else if (rs != r_exp) n_j = r_j + (RW+1)'(1);
                else if (bsum > 17'(r_cap)) n_st = S_DONE;
                else begin
                    n_bu = bsum[15:0]; n_exp = r_exp + 32'(rl);
                    n_rv[r_j[RW-1:0]] = 1'b0;
                    n_ndr = r_ndr + (RW+1)'(1); n_j = '0;
                end
            end
            S_DONE: if (!r_ov || !i_out_stall) begin
                n_out = r_res;
                if (r_res.action == rtae_pkg::ACT_ACK) n_out.ack_value = r_exp;
                n_out.adv_window = fw(r_cap, r_bu);
                n_out.cwnd_now = r_cw; n_out.peer_window = r_rw;
                n_out.fin_seen = r_fin;
                n_ov = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_exp <= r_ie; r_loc <= r_il; r_dv <= '0;
            r_hd <= '0; r_cnt <= '0; r_dc <= '0; r_cw <= r_cw0; r_rw <= r_cap;
            r_bu <= '0; r_fin <= 1'b0; r_rv <= '0; r_ov <= 1'b0; r_rd <= 1'b0;
        end else begin
            r_st <= n_st; r_exp <= n_exp; r_loc <= n_loc; r_dv <= n_dv;
            r_hd <= n_hd; r_cnt <= n_cnt; r_dc <= n_dc; r_cw <= n_cw; r_rw <= n_rw;
            r_bu <= n_bu; r_fin <= n_fin; r_rv <= n_rv; r_ov <= n_ov; r_rd <= n_rd;
        end
        r_it <= n_it; r_k <= n_k; r_j <= n_j; r_ndr <= n_ndr; r_free <= n_free;
        r_fnd <= n_fnd; r_res <= n_res; r_out <= n_out;
    end
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the reliable transport ack engine: a directed
// opening, then mostly well-formed traffic (in-order and reordered data,
// duplicate and cumulative acks, transmits, reads) built from the predicted
// connection state, under four register settings with random idle and stall
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SW_DEPTH   = 16;
    localparam int RO_DEPTH   = 16;
    localparam int CYCLE_CAP  = 5000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    rtae_pkg::t_in_item  i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rtae_pkg::t_out_item o_out;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [31:0]         i_cfg_data = '0;

    reliable_transport_ack_engine dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register shadows
    logic [31:0] cfg_init_exp, cfg_init_loc;
    int unsigned cfg_mss, cfg_cap, cfg_cwnd0, cfg_thresh;

    // predicted connection state
    logic [31:0] exp_seq, loc_seq;
    logic [31:0] sw_seq [SW_DEPTH];
    logic [31:0] sw_len [SW_DEPTH];
    int unsigned sw_head, sw_cnt;
    logic        ro_vld [RO_DEPTH];
    logic [31:0] ro_seq [RO_DEPTH];
    logic [31:0] ro_len [RO_DEPTH];
    logic [31:0] dup_val;
    int unsigned dup_cnt, cwnd, rwin, buf_used;
    logic        fin_flag;

    rtae_pkg::t_in_item  pending_items[$];
    rtae_pkg::t_out_item expected_results[$];
    int        n_mismatch = 0;
    int        n_fail = 0;
    bit        quiet = 1'b0;
    int        in_gap = 0;
    int        out_hold = 0;
    longint    cycles = 0;

    function automatic bit later(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic int find_stored(logic [31:0] s);
        for (int i = 0; i < RO_DEPTH; i++)
            if (ro_vld[i] && ro_seq[i] == s) return i;
        return -1;
    endfunction

    function automatic rtae_pkg::t_out_item predict(rtae_pkg::t_in_item t);
        rtae_pkg::t_out_item r;
        int          idx, slot;
        logic [31:0] seg_end;
        r = '0;
        case (t.operation)
            rtae_pkg::OP_TX_SEG: begin
                if (sw_cnt >= SW_DEPTH) begin
                    r.error = 1'b1;
                end else begin
                    idx = (sw_head + sw_cnt) % SW_DEPTH;
                    sw_seq[idx] = t.seq_number;
                    sw_len[idx] = 32'(t.seg_len);
                    sw_cnt++;
                    loc_seq = t.seq_number + 32'(t.seg_len);
                end
            end
            rtae_pkg::OP_APP_RD: begin
                buf_used = (t.read_len >= buf_used) ? 0 : buf_used - t.read_len;
            end
            rtae_pkg::OP_RX_HDR: begin
                if (t.flags[rtae_pkg::FLG_ACK_BIT]) begin
                    rwin = t.rx_window;
                    cwnd = cwnd + cfg_mss;
                    if (cwnd > 65535) cwnd = 65535;
                    if (sw_cnt != 0 && later(t.ack_number, sw_seq[sw_head])) begin
                        while (sw_cnt != 0) begin
                            seg_end = sw_seq[sw_head] + sw_len[sw_head];
                            if (later(seg_end, t.ack_number)) break;
                            sw_head = (sw_head + 1) % SW_DEPTH;
                            sw_cnt--;
                        end
                        dup_val = '0;
                        dup_cnt = 0;
                    end else begin
                        if (dup_cnt == 0 || dup_val != t.ack_number) begin
                            dup_val = t.ack_number;
                            dup_cnt = 0;
                        end
                        if (dup_cnt < 15) begin
                            dup_cnt++;
                            if (dup_cnt == cfg_thresh) begin
                                cwnd = cwnd / 2;
                                for (int k = 0; k < sw_cnt; k++) begin
                                    if (r.action == rtae_pkg::ACT_NONE &&
                                        sw_seq[(sw_head + k) % SW_DEPTH] == t.ack_number) begin
                                        r.action = rtae_pkg::ACT_RTX;
                                        r.retransmit_seq = t.ack_number;
                                    end
                                end
                            end
                        end
                    end
                end else if (t.flags[rtae_pkg::FLG_FIN_BIT]) begin
                    fin_flag = 1'b1;
                    rwin = t.rx_window;
                    r.action = rtae_pkg::ACT_FIN;
                    r.ack_value = t.seq_number + 32'd1;
                    r.seq_value = loc_seq;
                end else if (t.seq_number == exp_seq) begin
                    rwin = t.rx_window;
                    if (buf_used + t.seg_len > cfg_cap) begin
                        r.error = 1'b1;
                        r.action = rtae_pkg::ACT_DUP;
                    end else begin
                        buf_used += t.seg_len;
                        exp_seq += 32'(t.seg_len);
                        // pull stored segments that now line up
                        for (int n = 0; n < RO_DEPTH; n++) begin
                            idx = find_stored(exp_seq);
                            if (idx < 0) break;
                            if (buf_used + ro_len[idx] > cfg_cap) break;
                            buf_used += ro_len[idx];
                            exp_seq += ro_len[idx];
                            ro_vld[idx] = 1'b0;
                        end
                        r.action = rtae_pkg::ACT_ACK;
                    end
                    r.ack_value = exp_seq;
                    r.seq_value = loc_seq;
                end else if (later(t.seq_number, exp_seq)) begin
                    rwin = t.rx_window;
                    if (find_stored(t.seq_number) < 0) begin
                        slot = -1;
                        for (int i = 0; i < RO_DEPTH; i++)
                            if (slot < 0 && !ro_vld[i]) slot = i;
                        if (slot < 0) begin
                            r.error = 1'b1;
                        end else begin
                            ro_vld[slot] = 1'b1;
                            ro_seq[slot] = t.seq_number;
                            ro_len[slot] = 32'(t.seg_len);
                        end
                    end
                    r.action = rtae_pkg::ACT_DUP;
                    r.ack_value = exp_seq;
                    r.seq_value = loc_seq;
                end
            end
            default: ;
        endcase
        r.adv_window = (cfg_cap > buf_used) ? 16'(cfg_cap - buf_used) : 16'd0;
        r.cwnd_now = 16'(cwnd);
        r.peer_window = 16'(rwin);
        r.fin_seen = fin_flag;
        return r;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                expected_results.insert(expected_results.size(), predict(i_in));
                in_gap = quiet ? 0 : $urandom_range(0, 7);
            end
            if (in_gap == 0 && pending_items.size() != 0) begin
                i_in <= pending_items[0];
                pending_items.delete(0);
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
                if (in_gap > 0) in_gap--;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        rtae_pkg::t_out_item e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_mismatch++ < 10)
                        $display("unexpected transaction %p", o_out);
                end else begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    if (o_out.action !== e.action || o_out.ack_value !== e.ack_value ||
                        o_out.seq_value !== e.seq_value ||
                        o_out.adv_window !== e.adv_window ||
                        o_out.retransmit_seq !== e.retransmit_seq ||
                        o_out.cwnd_now !== e.cwnd_now ||
                        o_out.peer_window !== e.peer_window ||
                        o_out.fin_seen !== e.fin_seen || o_out.error !== e.error) begin
                        n_fail++;
                        if (n_mismatch++ < 10)
                            $display("mismatch: expected %p actual %p", e, o_out);
                    end
                end
                out_hold = quiet ? 0 : $urandom_range(0, 7);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("reliable_transport_ack_engine test failed");
            $finish;
        end
    end

    task automatic put(input logic [1:0] op, input logic [3:0] fl, input logic [31:0] sq,
                       input logic [31:0] ak, input logic [10:0] pl,
                       input logic [15:0] wn, input logic [15:0] rl);
        rtae_pkg::t_in_item t;
        while (pending_items.size() > 1) @(negedge i_clk);
        t.operation = op;
        t.flags = fl;
        t.seq_number = sq;
        t.ack_number = ak;
        t.seg_len = pl;
        t.rx_window = wn;
        t.read_len = rl;
        pending_items.insert(pending_items.size(), t);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            rtae_pkg::CFG_INIT_EXP: cfg_init_exp = val;
            rtae_pkg::CFG_INIT_LOC: cfg_init_loc = val;
            rtae_pkg::CFG_MSS:      cfg_mss = val[10:0];
            rtae_pkg::CFG_CAP:      cfg_cap = val[15:0];
            rtae_pkg::CFG_CWND0:    cfg_cwnd0 = val[15:0];
            rtae_pkg::CFG_THRESH:   cfg_thresh = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int count);
        int          kind, sel, clen, k;
        logic [31:0] a;
        logic [3:0]  fl;
        clen = $urandom_range(1, 600);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                clen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1500)
                                                 : $urandom_range(1, 400);
            end
            kind = $urandom_range(0, 99);
            fl = 4'($urandom);
            if (kind < 20) begin
                a = ($urandom_range(0, 19) == 0) ? $urandom : loc_seq;
                put(rtae_pkg::OP_TX_SEG, fl, a, $urandom, 11'($urandom_range(0, 1500)),
                    16'($urandom), 16'($urandom));
            end else if (kind < 40) begin
                sel = $urandom_range(0, 9);
                if (sw_cnt == 0 || sel == 0) begin
                    a = $urandom;
                end else if (sel < 6) begin
                    a = sw_seq[sw_head];
                end else begin
                    k = (sw_head + $urandom_range(0, sw_cnt - 1)) % SW_DEPTH;
                    a = sw_seq[k] + sw_len[k];
                end
                fl = ($urandom_range(0, 4) == 0) ? (fl | 4'b0010) : 4'b0010;
                put(rtae_pkg::OP_RX_HDR, fl, $urandom, a, 11'($urandom_range(0, 1500)),
                    16'($urandom), 16'($urandom));
            end else if (kind < 68) begin
                sel = $urandom_range(0, 9);
                fl = (sel == 0) ? 4'b0001 : (sel == 1) ? 4'b1000 : 4'b0000;
                if (sel < 5)
                    put(rtae_pkg::OP_RX_HDR, fl, exp_seq, $urandom, 11'(clen),
                        16'($urandom), 16'($urandom));
                else
                    put(rtae_pkg::OP_RX_HDR, fl, exp_seq + 32'(clen * $urandom_range(1, 3)),
                        $urandom, 11'(clen), 16'($urandom), 16'($urandom));
            end else if (kind < 82) begin
                put(rtae_pkg::OP_APP_RD, 4'($urandom), $urandom, $urandom,
                    11'($urandom_range(0, 1500)), 16'($urandom),
                    $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)));
            end else if (kind < 86) begin
                put(rtae_pkg::OP_RX_HDR, fl & 4'b1101 | 4'b0100, $urandom, $urandom,
                    11'($urandom_range(0, 1500)), 16'($urandom), 16'($urandom));
            end else if (kind < 93) begin
                put(2'($urandom_range(0, 3)), fl, $urandom, $urandom,
                    11'($urandom_range(0, 1500)), 16'($urandom), 16'($urandom));
            end else begin
                a = ($urandom_range(0, 2) == 0) ? exp_seq - $urandom_range(1, 5000)
                                                : exp_seq + $urandom_range(1, 1 << 20);
                put(rtae_pkg::OP_RX_HDR, fl & 4'b1001, a, $urandom,
                    11'($urandom_range(0, 1500)), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        cfg_init_exp = '0;
        cfg_init_loc = '0;
        cfg_mss = rtae_pkg::MSS_RST;
        cfg_cap = rtae_pkg::CAP_RST;
        cfg_cwnd0 = rtae_pkg::CWND0_RST;
        cfg_thresh = rtae_pkg::THRESH_RST;
        exp_seq = cfg_init_exp;
        loc_seq = cfg_init_loc;
        sw_head = 0;
        sw_cnt = 0;
        for (int i = 0; i < SW_DEPTH; i++) begin
            sw_seq[i] = '0;
            sw_len[i] = '0;
        end
        for (int i = 0; i < RO_DEPTH; i++) begin
            ro_vld[i] = 1'b0;
            ro_seq[i] = '0;
            ro_len[i] = '0;
        end
        dup_val = '0;
        dup_cnt = 0;
        cwnd = cfg_cwnd0;
        rwin = cfg_cap;
        buf_used = 0;
        fin_flag = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        put(rtae_pkg::OP_RSVD, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF, 11'd1500, 16'hFFFF, 16'hFFFF);
        put(rtae_pkg::OP_RX_HDR, 4'b0001, 32'd0, 32'd0, 11'd100, 16'd0, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b1000, 32'd100, 32'd0, 11'd0, 16'hFFFF, 16'd0);
        put(rtae_pkg::OP_TX_SEG, 4'd0, 32'd1000, 32'd0, 11'd500, 16'd0, 16'd0);
        put(rtae_pkg::OP_TX_SEG, 4'd0, 32'd1500, 32'd0, 11'd1500, 16'd0, 16'd0);
        put(rtae_pkg::OP_TX_SEG, 4'd0, 32'd3000, 32'd0, 11'd0, 16'd0, 16'd0);
        repeat (3) put(rtae_pkg::OP_RX_HDR, 4'b0010, 32'd0, 32'd1000, 11'd0, 16'hFFFF, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0111, 32'd0, 32'd1500, 11'd0, 16'd1234, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd100, 32'd0, 11'd1500, 16'd10, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd1600, 32'd0, 11'd1500, 16'd20, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd3100, 32'd0, 11'd1500, 16'd30, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd4000, 32'd0, 11'd10, 16'd40, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd50, 32'd0, 11'd10, 16'd50, 16'd0);
        put(rtae_pkg::OP_APP_RD, 4'd0, 32'd0, 32'd0, 11'd0, 16'd0, 16'hFFFF);
        put(rtae_pkg::OP_RX_HDR, 4'b0000, 32'd3100, 32'd0, 11'd900, 16'd60, 16'd0);
        put(rtae_pkg::OP_RX_HDR, 4'b0100, 32'hFFFFFFFF, 32'd0, 11'd0, 16'd70, 16'd0);
        put(rtae_pkg::OP_TX_SEG, 4'hF, 32'hFFFFFF00, 32'hFFFFFFFF, 11'd1500, 16'hFFFF,
            16'hFFFF);
        put(rtae_pkg::OP_RX_HDR, 4'b1010, 32'd0, 32'hFFFFFFFF, 11'd0, 16'd0, 16'd0);
        random_traffic(175);

        for (int ph = 1; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    cfg_write(rtae_pkg::CFG_INIT_EXP, 32'hFFFFFFFF);
                    cfg_write(rtae_pkg::CFG_INIT_LOC, 32'hFFFFFFFF);
                    cfg_write(rtae_pkg::CFG_MSS, 32'd1460);
                    cfg_write(rtae_pkg::CFG_CAP, 32'd65535);
                    cfg_write(rtae_pkg::CFG_CWND0, 32'd65535);
                    cfg_write(rtae_pkg::CFG_THRESH, 32'd1);
                end
                2: begin
                    cfg_write(rtae_pkg::CFG_INIT_EXP, 32'd0);
                    cfg_write(rtae_pkg::CFG_INIT_LOC, 32'd0);
                    cfg_write(rtae_pkg::CFG_MSS, 32'd1);
                    cfg_write(rtae_pkg::CFG_CAP, 32'd1);
                    cfg_write(rtae_pkg::CFG_CWND0, 32'd1);
                    cfg_write(rtae_pkg::CFG_THRESH, 32'd15);
                end
                default: begin
                    cfg_write(rtae_pkg::CFG_INIT_EXP, $urandom);
                    cfg_write(rtae_pkg::CFG_INIT_LOC, $urandom);
                    cfg_write(rtae_pkg::CFG_MSS, $urandom_range(1, 1460));
                    cfg_write(rtae_pkg::CFG_CAP, $urandom_range(1000, 20000));
                    cfg_write(rtae_pkg::CFG_CWND0, $urandom_range(1, 65535));
                    cfg_write(rtae_pkg::CFG_THRESH, 32'd2);
                end
            endcase
            random_traffic(175);
        end

        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("reliable_transport_ack_engine test passed");
        else
            $display("reliable_transport_ack_engine test failed");
        $finish;
    end

endmodule
